[design/vrgb_pkg.sv]
// ----------------------------------------------------------------------------
// vrgb_pkg
// shared types and constants of the value to rgb colour ramp
// ----------------------------------------------------------------------------
package vrgb_pkg;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef logic [1:0] cfg_idx_t;
  typedef logic [4:0] ramp_t;

  localparam cfg_idx_t CFG_RANGE_LOW   = 2'd0;
  localparam cfg_idx_t CFG_RANGE_HIGH  = 2'd1;
  localparam cfg_idx_t CFG_RAMP_SELECT = 2'd2;

  localparam ramp_t RAMP_RAINBOW       = 5'd1;
  localparam ramp_t RAMP_RED_BLUE      = 5'd2;
  localparam ramp_t RAMP_GREY          = 5'd3;
  localparam ramp_t RAMP_HUE           = 5'd4;
  localparam ramp_t RAMP_GREEN_YELLOW  = 5'd5;
  localparam ramp_t RAMP_GREEN_MAGENTA = 5'd6;
  localparam ramp_t RAMP_CYCLE         = 5'd7;
  localparam ramp_t RAMP_GREY_TENT     = 5'd8;
  localparam ramp_t RAMP_RED_CYAN_MAG  = 5'd9;
  localparam ramp_t RAMP_RAINBOW_WHITE = 5'd10;
  localparam ramp_t RAMP_EARTH         = 5'd11;
  localparam ramp_t RAMP_BROWN         = 5'd12;
  localparam ramp_t RAMP_LAND          = 5'd13;
  localparam ramp_t RAMP_YELLOW_RED    = 5'd14;
  localparam ramp_t RAMP_RAINBOW_PALE  = 5'd15;
  localparam ramp_t RAMP_BLUE_GREEN    = 5'd16;
  localparam ramp_t RAMP_MAGENTA_BLUE  = 5'd17;
  localparam ramp_t RAMP_BLUE_CYAN     = 5'd18;
  localparam ramp_t RAMP_BLUE_WHITE    = 5'd19;
  localparam ramp_t RAMP_FOREST        = 5'd20;
  localparam ramp_t RAMP_PASTEL        = 5'd21;
  localparam ramp_t RAMP_YELLOW_BLUE   = 5'd22;

  localparam rgb_t COL_M1 = '{r: 8'd200, g: 8'd60,  b: 8'd0};
  localparam rgb_t COL_M2 = '{r: 8'd250, g: 8'd160, b: 8'd110};
  localparam rgb_t COL_N1 = '{r: 8'd55,  g: 8'd55,  b: 8'd45};
  localparam rgb_t COL_N2 = '{r: 8'd235, g: 8'd90,  b: 8'd30};
  localparam rgb_t COL_L1 = '{r: 8'd0,   g: 8'd255, b: 8'd0};
  localparam rgb_t COL_L2 = '{r: 8'd255, g: 8'd150, b: 8'd0};
  localparam rgb_t COL_L3 = '{r: 8'd255, g: 8'd250, b: 8'd240};
  localparam rgb_t COL_K1 = '{r: 8'd0,   g: 8'd160, b: 8'd0};
  localparam rgb_t COL_K2 = '{r: 8'd180, g: 8'd220, b: 8'd0};
  localparam rgb_t COL_K3 = '{r: 8'd250, g: 8'd220, b: 8'd170};
  localparam rgb_t COL_Y1 = '{r: 8'd255, g: 8'd255, b: 8'd200};
  localparam rgb_t COL_Y2 = '{r: 8'd150, g: 8'd150, b: 8'd255};

endpackage

[design/vrgb_div.sv]
// ----------------------------------------------------------------------------
// vrgb_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module vrgb_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [NW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          vld_r  [NW];
  logic [DW-1:0] rem_r  [NW];
  logic [NW-1:0] num_r  [NW];
  logic [NW-1:0] quo_r  [NW];
  logic [DW-1:0] den_r  [NW];
  logic [SW-1:0] side_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic          vld_i;
    logic [DW-1:0] rem_i;
    logic [NW-1:0] num_i;
    logic [NW-1:0] quo_i;
    logic [DW-1:0] den_i;
    logic [SW-1:0] side_i;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    if (k == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = '0;
      assign num_i  = in_num;
      assign quo_i  = '0;
      assign den_i  = in_den;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign num_i  = num_r[k-1];
      assign quo_i  = quo_r[k-1];
      assign den_i  = den_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign trial = {rem_i, num_i[NW-1-k]};
    assign diff  = trial - {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_i;
      end
      rem_r[k]  <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
      num_r[k]  <= num_i;
      quo_r[k]  <= quo_i | ({{(NW-1){1'b0}}, ~diff[DW]} << (NW-1-k));
      den_r[k]  <= den_i;
      side_r[k] <= side_i;
    end
  end

  assign out_vld  = vld_r[NW-1];
  assign out_quo  = quo_r[NW-1];
  assign out_side = side_r[NW-1];

endmodule

[design/value_to_rgb_colour_ramp.sv]
// ----------------------------------------------------------------------------
// value_to_rgb_colour_ramp
// maps each sample to an rgb colour along one of 22 selectable ramps
//
// a sample word is taken at a clock edge with start high and busy low; busy
// stays low, so a new word may enter every cycle (one word per clock).
// the colour leaves on out_red/out_green/out_blue for one cycle marked by
// out_valid. a word passes stage a, the bit-per-stage range divider of
// SAMPLE_BITS + FRACTION_BITS stages, then stages b, q, c, m and o; the
// three-colour split is a reciprocal multiply in one stage, and every ramp
// runs through the same stages. the receiver cannot stall, so the pipe
// never holds.
// configuration words arrive on the cfg_ port, always ready: index 0 is the
// range low bound, 1 the high bound, 2 the ramp number; other indexes are
// dropped. write them only while no word is in flight.
// reset empties the pipe and loads low 0, high 65535, ramp 1.
// ----------------------------------------------------------------------------
module value_to_rgb_colour_ramp #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  output logic [7:0]             out_red,
  output logic [7:0]             out_green,
  output logic [7:0]             out_blue,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [SAMPLE_BITS-1:0] cfg_data
);

  localparam int S  = SAMPLE_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int XW = F + 11;
  localparam logic [F:0] ONE = (F+1)'(1) << F;
  localparam int SW2 = 5 + 3 + 1 + 2 * (F + 1);
  localparam int QK = F + 6;
  localparam logic [F+5:0] REC2 = (F+6)'(64'd1 << (QK - 1));
  localparam logic [F+5:0] REC3 = (F+6)'(((64'd1 << QK) + 64'd2) / 64'd3);
  localparam logic [F+5:0] REC7 = (F+6)'(((64'd1 << QK) + 64'd6) / 64'd7);

  // configuration
  logic [S-1:0] range_low_r;
  logic [S-1:0] range_high_r;
  logic [4:0]   ramp_select_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r   <= '0;
      range_high_r  <= S'(65535);
      ramp_select_r <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vrgb_pkg::CFG_RANGE_LOW:   range_low_r   <= cfg_data;
        vrgb_pkg::CFG_RANGE_HIGH:  range_high_r  <= cfg_data;
        vrgb_pkg::CFG_RAMP_SELECT: ramp_select_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // stage a: order bounds, clip, offset; equal bounds place the sample below, at or above them
  logic         a_vld_r;
  logic [S-1:0] a_num_r, a_num_nxt;
  logic [S-1:0] a_den_r, a_den_nxt;
  logic [4:0]   a_sel_r;

  always_comb begin
    logic [S-1:0] lo, hi, v;
    lo = (range_high_r < range_low_r) ? range_high_r : range_low_r;
    hi = (range_high_r < range_low_r) ? range_low_r : range_high_r;
    v = in_sample;
    if (lo == hi) begin
      a_den_nxt = S'(2);
      if (in_sample < lo) begin
        a_num_nxt = '0;
      end else if (in_sample == lo) begin
        a_num_nxt = S'(1);
      end else begin
        a_num_nxt = S'(2);
      end
    end else begin
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      a_num_nxt = v - lo;
      a_den_nxt = hi - lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start && !busy;
    end
    a_num_r <= a_num_nxt;
    a_den_r <= a_den_nxt;
    a_sel_r <= ramp_select_r;
  end

  // range fraction t
  logic           d1_vld;
  logic [S+F-1:0] d1_quo;
  logic [4:0]     d1_sel;

  vrgb_div #(.NW(S + F), .DW(S), .SW(5)) u_div_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (a_vld_r),
    .in_num   ({a_num_r, {F{1'b0}}}),
    .in_den   (a_den_r),
    .in_side  (a_sel_r),
    .out_vld  (d1_vld),
    .out_quo  (d1_quo),
    .out_side (d1_sel)
  );

  // stage b: segments and three-colour split
  logic         b_vld_r;
  logic [4:0]   b_sel_r;
  logic [F:0]   b_t_r;
  logic [2:0]   b_s_r, b_s_nxt;
  logic [F:0]   b_u_r, b_u_nxt;
  logic         b_low_r, b_low_nxt;
  logic [F+3:0] b_x_r, b_x_nxt;
  logic [F+5:0] b_m_r, b_m_nxt;

  always_comb begin
    logic [F:0]   t;
    logic [2:0]   n, s_raw;
    logic [F+3:0] p, t5, bt, thr;
    logic [F+2:0] pw;
    t = d1_quo[F:0];
    case (d1_sel)
      vrgb_pkg::RAMP_HUE:           n = 3'd6;
      vrgb_pkg::RAMP_RED_CYAN_MAG:  n = 3'd3;
      vrgb_pkg::RAMP_RAINBOW_WHITE: n = 3'd5;
      vrgb_pkg::RAMP_GREY_TENT,
      vrgb_pkg::RAMP_BLUE_GREEN,
      vrgb_pkg::RAMP_MAGENTA_BLUE:  n = 3'd2;
      default:                      n = 3'd4;
    endcase
    p = {3'b0, t} * (F+4)'(n);
    s_raw = p[F+2:F];
    b_s_nxt = (s_raw >= n) ? n - 3'd1 : s_raw;
    pw = p[F+2:0] - {b_s_nxt, {F{1'b0}}};
    b_u_nxt = pw[F:0];

    t5 = {1'b0, t, 2'b0} + {3'b0, t};
    if (d1_sel == vrgb_pkg::RAMP_BROWN) begin
      bt  = t5;
      thr = {2'b0, ONE, 1'b0};
      if (bt < thr) begin
        b_low_nxt = 1'b1;
        b_x_nxt   = bt;
        b_m_nxt   = REC2;
      end else begin
        b_low_nxt = 1'b0;
        b_x_nxt   = bt - thr;
        b_m_nxt   = REC3;
      end
    end else begin
      bt  = {t5[F+2:0], 1'b0};
      thr = {2'b0, ONE, 1'b0} + {3'b0, ONE};
      if (bt < thr) begin
        b_low_nxt = 1'b1;
        b_x_nxt   = bt;
        b_m_nxt   = REC3;
      end else begin
        b_low_nxt = 1'b0;
        b_x_nxt   = bt - thr;
        b_m_nxt   = REC7;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= d1_vld;
    end
    b_sel_r <= d1_sel;
    b_t_r   <= d1_quo[F:0];
    b_s_r   <= b_s_nxt;
    b_u_r   <= b_u_nxt;
    b_low_r <= b_low_nxt;
    b_x_r   <= b_x_nxt;
    b_m_r   <= b_m_nxt;
  end

  // stage q: three-colour local fraction by reciprocal multiply
  logic           q_vld_r;
  logic [F:0]     q_quo_r;
  logic [SW2-1:0] q_side_r;
  logic [2*F+9:0] q_prod;

  assign q_prod = b_x_r * b_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= 1'b0;
    end else begin
      q_vld_r <= b_vld_r;
    end
    q_quo_r  <= q_prod[QK +: F+1];
    q_side_r <= {b_sel_r, b_s_r, b_low_r, b_t_r, b_u_r};
  end

  // stage c: per channel base, slope and fraction
  logic              c_vld_r;
  logic [7:0]        c_base_r  [3];
  logic signed [8:0] c_slope_r [3];
  logic [F:0]        c_frac_r  [3];
  logic [7:0]        c_base_nxt  [3];
  logic signed [8:0] c_slope_nxt [3];
  logic [F:0]        c_frac_nxt  [3];

  always_comb begin
    logic [4:0]     sel;
    logic [2:0]     s;
    logic           low;
    logic [F:0]     t, u, z, omt, ud, ml;
    logic [F:0]     fr [3];
    logic           lerp;
    vrgb_pkg::rgb_t ca, cb;
    sel = q_side_r[SW2-1 -: 5];
    s   = q_side_r[SW2-6 -: 3];
    low = q_side_r[2*(F+1)];
    t   = q_side_r[2*(F+1)-1 -: F+1];
    u   = q_side_r[F:0];
    z   = ONE - u;
    omt = ONE - t;
    ud  = q_quo_r;
    fr[0] = ONE; fr[1] = ONE; fr[2] = ONE;
    lerp = 1'b0;
    ca = vrgb_pkg::COL_M1;
    cb = vrgb_pkg::COL_M2;
    ml = t;
    case (sel)
      vrgb_pkg::RAMP_RAINBOW: begin
        case (s)
          3'd0:    begin fr[0] = '0;  fr[1] = u;   fr[2] = ONE; end
          3'd1:    begin fr[0] = '0;  fr[1] = ONE; fr[2] = z;   end
          3'd2:    begin fr[0] = u;   fr[1] = ONE; fr[2] = '0;  end
          default: begin fr[0] = ONE; fr[1] = z;   fr[2] = '0;  end
        endcase
      end
      vrgb_pkg::RAMP_RED_BLUE: begin fr[0] = t; fr[1] = '0; fr[2] = omt; end
      vrgb_pkg::RAMP_GREY:     begin fr[0] = t; fr[1] = t;  fr[2] = t;   end
      vrgb_pkg::RAMP_HUE: begin
        case (s)
          3'd0:    begin fr[0] = ONE; fr[1] = u;   fr[2] = '0;  end
          3'd1:    begin fr[0] = z;   fr[1] = ONE; fr[2] = '0;  end
          3'd2:    begin fr[0] = '0;  fr[1] = ONE; fr[2] = u;   end
          3'd3:    begin fr[0] = '0;  fr[1] = z;   fr[2] = ONE; end
          3'd4:    begin fr[0] = u;   fr[1] = '0;  fr[2] = ONE; end
          default: begin fr[0] = ONE; fr[1] = '0;  fr[2] = z;   end
        endcase
      end
      vrgb_pkg::RAMP_GREEN_YELLOW:  begin fr[0] = t; fr[1] = ONE; fr[2] = '0; end
      vrgb_pkg::RAMP_GREEN_MAGENTA: begin fr[0] = t; fr[1] = omt; fr[2] = t;  end
      vrgb_pkg::RAMP_CYCLE: begin
        case (s)
          3'd0:    begin fr[0] = '0; fr[1] = u; fr[2] = z;  end
          3'd1:    begin fr[0] = u;  fr[1] = z; fr[2] = '0; end
          3'd2:    begin fr[0] = z;  fr[1] = u; fr[2] = '0; end
          default: begin fr[0] = '0; fr[1] = z; fr[2] = u;  end
        endcase
      end
      vrgb_pkg::RAMP_GREY_TENT: begin
        if (s == 3'd0) begin
          fr[0] = u; fr[1] = u; fr[2] = u;
        end else begin
          fr[0] = z; fr[1] = z; fr[2] = z;
        end
      end
      vrgb_pkg::RAMP_RED_CYAN_MAG: begin
        case (s)
          3'd0:    begin fr[0] = z;  fr[1] = '0; fr[2] = u;   end
          3'd1:    begin fr[0] = '0; fr[1] = u;  fr[2] = ONE; end
          default: begin fr[0] = u;  fr[1] = z;  fr[2] = ONE; end
        endcase
      end
      vrgb_pkg::RAMP_RAINBOW_WHITE: begin
        case (s)
          3'd0:    begin fr[0] = '0;  fr[1] = u;   fr[2] = ONE; end
          3'd1:    begin fr[0] = '0;  fr[1] = ONE; fr[2] = z;   end
          3'd2:    begin fr[0] = u;   fr[1] = ONE; fr[2] = '0;  end
          3'd3:    begin fr[0] = ONE; fr[1] = z;   fr[2] = '0;  end
          default: begin fr[0] = ONE; fr[1] = u;   fr[2] = u;   end
        endcase
      end
      vrgb_pkg::RAMP_EARTH: begin
        lerp = 1'b1; ca = vrgb_pkg::COL_M1; cb = vrgb_pkg::COL_M2; ml = t;
      end
      vrgb_pkg::RAMP_BROWN: begin
        lerp = 1'b1; ml = ud;
        ca = low ? vrgb_pkg::COL_N1 : vrgb_pkg::COL_N2;
        cb = low ? vrgb_pkg::COL_N2 : vrgb_pkg::COL_M2;
      end
      vrgb_pkg::RAMP_LAND: begin
        lerp = 1'b1; ml = ud;
        ca = low ? vrgb_pkg::COL_L1 : vrgb_pkg::COL_L2;
        cb = low ? vrgb_pkg::COL_L2 : vrgb_pkg::COL_L3;
      end
      vrgb_pkg::RAMP_YELLOW_RED: begin fr[0] = ONE; fr[1] = omt; fr[2] = '0; end
      vrgb_pkg::RAMP_RAINBOW_PALE: begin
        case (s)
          3'd0:    begin fr[0] = '0;  fr[1] = u;   fr[2] = ONE; end
          3'd1:    begin fr[0] = '0;  fr[1] = ONE; fr[2] = z;   end
          3'd2:    begin fr[0] = u;   fr[1] = ONE; fr[2] = '0;  end
          default: begin fr[0] = ONE; fr[1] = ONE; fr[2] = u;   end
        endcase
      end
      vrgb_pkg::RAMP_BLUE_GREEN: begin
        if (s == 3'd0) begin
          fr[0] = '0; fr[1] = u; fr[2] = z;
        end else begin
          fr[0] = u; fr[1] = z; fr[2] = '0;
        end
      end
      vrgb_pkg::RAMP_MAGENTA_BLUE: begin
        if (s == 3'd0) begin
          fr[0] = ONE; fr[1] = z; fr[2] = u;
        end else begin
          fr[0] = z; fr[1] = u; fr[2] = ONE;
        end
      end
      vrgb_pkg::RAMP_BLUE_CYAN:  begin fr[0] = '0; fr[1] = t; fr[2] = ONE; end
      vrgb_pkg::RAMP_BLUE_WHITE: begin fr[0] = t;  fr[1] = t; fr[2] = ONE; end
      vrgb_pkg::RAMP_FOREST: begin
        lerp = 1'b1; ml = ud;
        ca = low ? vrgb_pkg::COL_K1 : vrgb_pkg::COL_K2;
        cb = low ? vrgb_pkg::COL_K2 : vrgb_pkg::COL_K3;
      end
      vrgb_pkg::RAMP_PASTEL: begin
        lerp = 1'b1; ca = vrgb_pkg::COL_Y1; cb = vrgb_pkg::COL_Y2; ml = t;
      end
      vrgb_pkg::RAMP_YELLOW_BLUE: begin fr[0] = omt; fr[1] = omt; fr[2] = t; end
      default: ;
    endcase

    if (lerp) begin
      c_base_nxt[0]  = ca.r;
      c_base_nxt[1]  = ca.g;
      c_base_nxt[2]  = ca.b;
      c_slope_nxt[0] = $signed({1'b0, cb.r}) - $signed({1'b0, ca.r});
      c_slope_nxt[1] = $signed({1'b0, cb.g}) - $signed({1'b0, ca.g});
      c_slope_nxt[2] = $signed({1'b0, cb.b}) - $signed({1'b0, ca.b});
      c_frac_nxt[0]  = ml;
      c_frac_nxt[1]  = ml;
      c_frac_nxt[2]  = ml;
    end else begin
      for (int k = 0; k < 3; k++) begin
        c_base_nxt[k]  = 8'd0;
        c_slope_nxt[k] = 9'sd255;
        c_frac_nxt[k]  = fr[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= q_vld_r;
    end
    c_base_r  <= c_base_nxt;
    c_slope_r <= c_slope_nxt;
    c_frac_r  <= c_frac_nxt;
  end

  // stage m: base plus slope times fraction (255 times the fraction for plain ramps), with fraction bits
  logic                 m_vld_r;
  logic signed [XW-1:0] m_val_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= c_vld_r;
    end
    for (int k = 0; k < 3; k++) begin
      m_val_r[k] <= $signed({3'b0, c_base_r[k], {F{1'b0}}})
                  + XW'(c_slope_r[k] * $signed({1'b0, c_frac_r[k]}));
    end
  end

  // stage o: round half up and saturate
  logic       o_vld_r;
  logic [7:0] o_ch_r [3];
  logic [7:0] o_ch_nxt [3];

  always_comb begin
    logic signed [XW-1:0] y;
    for (int k = 0; k < 3; k++) begin
      y = m_val_r[k] + $signed(XW'(ONE >> 1));
      if (m_val_r[k] < 0) begin
        o_ch_nxt[k] = 8'd0;
      end else if (y[XW-1:F] > (XW-F)'(255)) begin
        o_ch_nxt[k] = 8'd255;
      end else begin
        o_ch_nxt[k] = y[F+7:F];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= m_vld_r;
    end
    o_ch_r <= o_ch_nxt;
  end

  assign out_valid = o_vld_r;
  assign out_red   = o_ch_r[0];
  assign out_green = o_ch_r[1];
  assign out_blue  = o_ch_r[2];

endmodule

[dv/value_to_rgb_colour_ramp_tb.sv]
// ----------------------------------------------------------------------------
// value_to_rgb_colour_ramp testbench
// drives sample words through the colour ramp under every ramp number and
// several range settings, predicts each colour in fixed point and checks
// every output word in order against the prediction
// ----------------------------------------------------------------------------
module value_to_rgb_colour_ramp_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam longint ONE = 64'd1 << FB;
  localparam int LATENCY = 38;
  localparam longint LIMIT = 400000;

  class colour_board;
    logic [15:0] lo_reg = 16'd0;
    logic [15:0] hi_reg = 16'hffff;
    vrgb_pkg::ramp_t ramp = vrgb_pkg::RAMP_RAINBOW;
    vrgb_pkg::rgb_t pending[$];
    int checked = 0;
    int errors = 0;
    longint chan[3];

    function void put(longint r, longint g, longint b);
      chan[0] = r * 255;
      chan[1] = g * 255;
      chan[2] = b * 255;
    endfunction

    function void blend(vrgb_pkg::rgb_t c1, vrgb_pkg::rgb_t c2, longint u);
      chan[0] = longint'(c1.r) * ONE + (longint'(c2.r) - longint'(c1.r)) * u;
      chan[1] = longint'(c1.g) * ONE + (longint'(c2.g) - longint'(c1.g)) * u;
      chan[2] = longint'(c1.b) * ONE + (longint'(c2.b) - longint'(c1.b)) * u;
    endfunction

    function void split3(vrgb_pkg::rgb_t c1, vrgb_pkg::rgb_t c2, vrgb_pkg::rgb_t c3,
                         longint a, longint b, longint t);
      longint bt;
      bt = b * t;
      if (bt < a * ONE) blend(c1, c2, bt / a);
      else blend(c2, c3, (bt - a * ONE) / (b - a));
    endfunction

    function logic [7:0] to_byte(longint x);
      longint o;
      if (x < 0) return 8'd0;
      o = (x + ONE / 2) >>> FB;
      return (o > 255) ? 8'd255 : o[7:0];
    endfunction

    function void note_sample(logic [15:0] smp);
      longint lo, hi, v, tmp, t, n, p, s, u, z;
      vrgb_pkg::rgb_t c;
      lo = lo_reg;
      hi = hi_reg;
      v = smp;
      if (hi < lo) begin
        tmp = lo; lo = hi; hi = tmp;
      end
      if (hi == lo) begin
        lo -= 1; hi += 1;
      end
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      t = ((v - lo) << FB) / (hi - lo);
      case (ramp)
        vrgb_pkg::RAMP_HUE: n = 6;
        vrgb_pkg::RAMP_RED_CYAN_MAG: n = 3;
        vrgb_pkg::RAMP_RAINBOW_WHITE: n = 5;
        vrgb_pkg::RAMP_GREY_TENT, vrgb_pkg::RAMP_BLUE_GREEN,
        vrgb_pkg::RAMP_MAGENTA_BLUE: n = 2;
        default: n = 4;
      endcase
      p = t * n;
      s = p >>> FB;
      if (s >= n) s = n - 1;
      u = p - s * ONE;
      z = ONE - u;
      put(ONE, ONE, ONE);
      case (ramp)
        vrgb_pkg::RAMP_RAINBOW: begin
          if (s == 0) put(0, u, ONE);
          else if (s == 1) put(0, ONE, z);
          else if (s == 2) put(u, ONE, 0);
          else put(ONE, z, 0);
        end
        vrgb_pkg::RAMP_RED_BLUE: put(t, 0, ONE - t);
        vrgb_pkg::RAMP_GREY: put(t, t, t);
        vrgb_pkg::RAMP_HUE: begin
          if (s == 0) put(ONE, u, 0);
          else if (s == 1) put(z, ONE, 0);
          else if (s == 2) put(0, ONE, u);
          else if (s == 3) put(0, z, ONE);
          else if (s == 4) put(u, 0, ONE);
          else put(ONE, 0, z);
        end
        vrgb_pkg::RAMP_GREEN_YELLOW: put(t, ONE, 0);
        vrgb_pkg::RAMP_GREEN_MAGENTA: put(t, ONE - t, t);
        vrgb_pkg::RAMP_CYCLE: begin
          if (s == 0) put(0, u, z);
          else if (s == 1) put(u, z, 0);
          else if (s == 2) put(z, u, 0);
          else put(0, z, u);
        end
        vrgb_pkg::RAMP_GREY_TENT: begin
          if (s == 0) put(u, u, u);
          else put(z, z, z);
        end
        vrgb_pkg::RAMP_RED_CYAN_MAG: begin
          if (s == 0) put(z, 0, u);
          else if (s == 1) put(0, u, ONE);
          else put(u, z, ONE);
        end
        vrgb_pkg::RAMP_RAINBOW_WHITE: begin
          if (s == 0) put(0, u, ONE);
          else if (s == 1) put(0, ONE, z);
          else if (s == 2) put(u, ONE, 0);
          else if (s == 3) put(ONE, z, 0);
          else put(ONE, u, u);
        end
        vrgb_pkg::RAMP_EARTH: blend(vrgb_pkg::COL_M1, vrgb_pkg::COL_M2, t);
        vrgb_pkg::RAMP_BROWN:
          split3(vrgb_pkg::COL_N1, vrgb_pkg::COL_N2, vrgb_pkg::COL_M2, 2, 5, t);
        vrgb_pkg::RAMP_LAND:
          split3(vrgb_pkg::COL_L1, vrgb_pkg::COL_L2, vrgb_pkg::COL_L3, 3, 10, t);
        vrgb_pkg::RAMP_YELLOW_RED: put(ONE, ONE - t, 0);
        vrgb_pkg::RAMP_RAINBOW_PALE: begin
          if (s == 0) put(0, u, ONE);
          else if (s == 1) put(0, ONE, z);
          else if (s == 2) put(u, ONE, 0);
          else put(ONE, ONE, u);
        end
        vrgb_pkg::RAMP_BLUE_GREEN: begin
          if (s == 0) put(0, u, z);
          else put(u, z, 0);
        end
        vrgb_pkg::RAMP_MAGENTA_BLUE: begin
          if (s == 0) put(ONE, z, u);
          else put(z, u, ONE);
        end
        vrgb_pkg::RAMP_BLUE_CYAN: put(0, t, ONE);
        vrgb_pkg::RAMP_BLUE_WHITE: put(t, t, ONE);
        vrgb_pkg::RAMP_FOREST:
          split3(vrgb_pkg::COL_K1, vrgb_pkg::COL_K2, vrgb_pkg::COL_K3, 3, 10, t);
        vrgb_pkg::RAMP_PASTEL: blend(vrgb_pkg::COL_Y1, vrgb_pkg::COL_Y2, t);
        vrgb_pkg::RAMP_YELLOW_BLUE: put(ONE - t, ONE - t, t);
        default: ;
      endcase
      c.r = to_byte(chan[0]);
      c.g = to_byte(chan[1]);
      c.b = to_byte(chan[2]);
      pending.push_back(c);
    endfunction

    function void check_colour(vrgb_pkg::rgb_t got);
      vrgb_pkg::rgb_t want;
      if (pending.size() == 0) begin
        $error("unexpected colour word %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.r !== want.r) begin
        $error("red: expected %0d actual %0d", want.r, got.r); errors++;
      end
      if (got.g !== want.g) begin
        $error("green: expected %0d actual %0d", want.g, got.g); errors++;
      end
      if (got.b !== want.b) begin
        $error("blue: expected %0d actual %0d", want.b, got.b); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] in_sample = '0;
  logic out_valid;
  logic [7:0] out_red, out_green, out_blue;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  longint cycles = 0;
  int configs = 0;
  colour_board board;

  value_to_rgb_colour_ramp dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_n && out_valid) board.check_colour('{r: out_red, g: out_green, b: out_blue});
  end

  task automatic idle_gap(int maxlen);
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, maxlen) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_sample(logic [15:0] smp);
    start <= 1'b1;
    in_sample <= smp;
    do @(posedge clk); while (busy);
    board.note_sample(smp);
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(vrgb_pkg::cfg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      vrgb_pkg::CFG_RANGE_LOW: board.lo_reg = val;
      vrgb_pkg::CFG_RANGE_HIGH: board.hi_reg = val;
      vrgb_pkg::CFG_RAMP_SELECT: board.ramp = val[4:0];
      default: ;
    endcase
    configs++;
    @(negedge clk);
  endtask

  task automatic setup(logic [15:0] lo, logic [15:0] hi, vrgb_pkg::ramp_t r);
    drain();
    write_reg(vrgb_pkg::CFG_RANGE_LOW, lo);
    write_reg(vrgb_pkg::CFG_RANGE_HIGH, hi);
    write_reg(vrgb_pkg::CFG_RAMP_SELECT, {11'd0, r});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_sample(logic [15:0] lo, logic [15:0] hi);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'h0000;
    if (k == 1) return 16'hffff;
    if (k == 2) return lo;
    if (k == 3) return hi;
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    logic [15:0] lo, hi;
    board = new();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: default config, extremes and boundaries
    send_sample(16'h0000);
    send_sample(16'hffff);
    send_sample(16'h4000);
    send_sample(16'h8000);
    send_sample(16'hc000);
    send_sample(16'h5555);
    send_sample(16'haaaa);
    // unknown ramps give white, reversed and equal bounds, three-colour split boundaries
    setup(16'd0, 16'hffff, 5'd0);
    send_sample(16'h1234);
    setup(16'd0, 16'hffff, 5'd31);
    send_sample(16'hedcb);
    setup(16'hffff, 16'd0, vrgb_pkg::RAMP_GREY);
    send_sample(16'h0000);
    send_sample(16'h7fff);
    send_sample(16'hffff);
    setup(16'd100, 16'd100, vrgb_pkg::RAMP_RAINBOW);
    send_sample(16'd0);
    send_sample(16'd100);
    send_sample(16'hffff);
    setup(16'd0, 16'd3, vrgb_pkg::RAMP_LAND);
    send_sample(16'd1);
    send_sample(16'd2);
    setup(16'd0, 16'd5, vrgb_pkg::RAMP_BROWN);
    send_sample(16'd2);
    send_sample(16'd3);

    // random: every ramp, mixed ranges
    for (int ph = 0; ph < 40; ph++) begin
      case (ph % 4)
        0: begin lo = 16'd0; hi = 16'hffff; end
        1: begin
          lo = 16'($urandom_range(0, 65535));
          hi = 16'($urandom_range(0, 65535));
        end
        2: begin lo = 16'($urandom_range(0, 200)); hi = lo + 16'($urandom_range(0, 12)); end
        default: begin lo = 16'hffff; hi = 16'($urandom_range(0, 65535)); end
      endcase
      setup(lo, hi, (ph < 32) ? ph[4:0] : vrgb_pkg::ramp_t'($urandom_range(0, 31)));
      for (int i = 0; i < 25; i++) begin
        if (ph % 3 != 0) idle_gap(30);
        send_sample(pick_sample(lo, hi));
      end
    end

    drain();
    $display("covered %0d colour words over %0d register writes, all ramp numbers",
             board.checked, configs);
    $display("range settings included full, reversed, equal and tiny spans");
    if (board.errors == 0 && board.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
